/* hdl/u8nv_pkg.sv */
// ----------------------------------------------------------------------------
// u8nv_pkg
// Shared types and constants for the UTF-8 name validator.
// ----------------------------------------------------------------------------
package u8nv_pkg;

  localparam int unsigned LimitW = 16;
  localparam int unsigned CountW = 17;
  localparam int unsigned AccumW = 21;

  typedef enum logic [2:0] {
    REASON_OK        = 3'd0,
    REASON_CONTROL   = 3'd1,
    REASON_BAD_LEAD  = 3'd2,
    REASON_BAD_CONT  = 3'd3,
    REASON_BAD_CP    = 3'd4,
    REASON_TRUNCATED = 3'd5,
    REASON_TOO_LONG  = 3'd6
  } reason_t;

  localparam logic [LimitW-1:0] LIMIT_RESET = 16'd255;
  localparam logic [CountW-1:0] COUNT_MAX   = 17'h1ffff;

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_DEL   = 8'h7f;
  localparam logic [7:0] LEAD2_LO    = 8'hc2;
  localparam logic [7:0] LEAD2_HI    = 8'hdf;
  localparam logic [7:0] LEAD3_LO    = 8'he0;
  localparam logic [7:0] LEAD3_HI    = 8'hef;
  localparam logic [7:0] LEAD4_LO    = 8'hf0;
  localparam logic [7:0] LEAD4_HI    = 8'hf4;

  localparam logic [AccumW-1:0] CP_MIN2     = 21'h80;
  localparam logic [AccumW-1:0] CP_MIN3     = 21'h800;
  localparam logic [AccumW-1:0] CP_MIN4     = 21'h10000;
  localparam logic [AccumW-1:0] CP_MAX      = 21'h10ffff;
  localparam logic [AccumW-1:0] SURR_LO     = 21'hd800;
  localparam logic [AccumW-1:0] SURR_HI     = 21'hdfff;
  localparam logic [AccumW-1:0] C1_LO       = 21'h80;
  localparam logic [AccumW-1:0] C1_HI       = 21'h9f;

endpackage

/* hdl/u8nv_in_if.sv */
// ----------------------------------------------------------------------------
// u8nv_in_if
// Byte channel into the validator: one name byte and its last marker.
// ----------------------------------------------------------------------------
interface u8nv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hdl/u8nv_out_if.sv */
// ----------------------------------------------------------------------------
// u8nv_out_if
// Verdict channel out of the validator: one word per name.
// ----------------------------------------------------------------------------
interface u8nv_out_if;
  logic       valid;
  logic       ready;
  logic       name_valid;
  logic [2:0] fail_reason;

  modport source (output valid, output name_valid, output fail_reason, input ready);
  modport sink   (input valid, input name_valid, input fail_reason, output ready);
endinterface

/* hdl/utf8_name_validator_unit.sv */
// ----------------------------------------------------------------------------
// utf8_name_validator_unit
// Strict UTF-8 name checker with a byte length limit and a reason code.
// ----------------------------------------------------------------------------
//  channel   dir   word                          handshake
//  in_if     in    data_byte[7:0], last_byte     valid/ready
//  out_if    out   name_valid, fail_reason[2:0]  valid/ready
//  cfg_*     in    max_name_bytes[15:0]          cfg_wr_en strobe
//
//  one byte per cycle while no last byte is stalled; a byte sits in the
//  input register, is decoded there, and its verdict (last byte) is registered
//  throughput is set by the single decode stage between the two registers
//  a pending verdict that is not taken stalls only last bytes; other bytes
//  keep flowing through the decode stage
//  synchronous active-low reset clears all name state, limit resets to 255
// ----------------------------------------------------------------------------
module utf8_name_validator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  u8nv_in_if.sink                       in_if,
  u8nv_out_if.source                    out_if,
  input  logic                          cfg_wr_en,
  input  logic [u8nv_pkg::LimitW-1:0]   cfg_wr_data
);

  logic [u8nv_pkg::LimitW-1:0] limit_r;

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // name state
  logic [1:0]                  pend_r,  pend_nxt;
  logic [1:0]                  seq_r,   seq_nxt;
  logic [u8nv_pkg::AccumW-1:0] acc_r,   acc_nxt;
  logic [u8nv_pkg::CountW-1:0] cnt_r,   cnt_nxt;
  u8nv_pkg::reason_t           err_r,   err_nxt;

  // result register
  logic                        out_v_r;
  u8nv_pkg::reason_t           reason_r, reason_nxt;

  logic out_free;
  logic fire;

  assign out_free = !out_v_r || out_if.ready;
  assign fire     = in_v_r && (!in_last_r || out_free);
  assign in_if.ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= u8nv_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.data_byte;
      in_last_r <= in_if.last_byte;
    end
  end

  // decode one byte against the current name state
  always_comb begin
    logic [7:0]                  b;
    logic [u8nv_pkg::AccumW-1:0] cp;
    logic [u8nv_pkg::AccumW-1:0] cp_min;
    logic [u8nv_pkg::LimitW-1:0] limit;
    b        = in_byte_r;
    pend_nxt = pend_r;
    seq_nxt  = seq_r;
    acc_nxt  = acc_r;
    err_nxt  = err_r;
    cp       = '0;
    cp_min   = u8nv_pkg::CP_MIN4;
    cnt_nxt  = (cnt_r == u8nv_pkg::COUNT_MAX) ? cnt_r : cnt_r + 1'b1;

    if (err_r == u8nv_pkg::REASON_OK) begin
      if (pend_r == 2'd0) begin
        if (!b[7]) begin
          if (b < u8nv_pkg::ASCII_SPACE || b == u8nv_pkg::ASCII_DEL) begin
            err_nxt = u8nv_pkg::REASON_CONTROL;
          end
        end else if (b >= u8nv_pkg::LEAD2_LO && b <= u8nv_pkg::LEAD2_HI) begin
          pend_nxt = 2'd1;
          seq_nxt  = 2'd1;
          acc_nxt  = {16'd0, b[4:0]};
        end else if (b >= u8nv_pkg::LEAD3_LO && b <= u8nv_pkg::LEAD3_HI) begin
          pend_nxt = 2'd2;
          seq_nxt  = 2'd2;
          acc_nxt  = {17'd0, b[3:0]};
        end else if (b >= u8nv_pkg::LEAD4_LO && b <= u8nv_pkg::LEAD4_HI) begin
          pend_nxt = 2'd3;
          seq_nxt  = 2'd3;
          acc_nxt  = {18'd0, b[2:0]};
        end else begin
          err_nxt = u8nv_pkg::REASON_BAD_LEAD;
        end
      end else if (b[7:6] != 2'b10) begin
        err_nxt = u8nv_pkg::REASON_BAD_CONT;
      end else begin
        cp       = {acc_r[u8nv_pkg::AccumW-7:0], b[5:0]};
        acc_nxt  = cp;
        pend_nxt = pend_r - 2'd1;
        unique case (seq_r)
          2'd1:    cp_min = u8nv_pkg::CP_MIN2;
          2'd2:    cp_min = u8nv_pkg::CP_MIN3;
          default: cp_min = u8nv_pkg::CP_MIN4;
        endcase
        if (pend_r == 2'd1 &&
            (cp < cp_min || cp > u8nv_pkg::CP_MAX ||
             (cp >= u8nv_pkg::SURR_LO && cp <= u8nv_pkg::SURR_HI) ||
             (cp >= u8nv_pkg::C1_LO && cp <= u8nv_pkg::C1_HI))) begin
          err_nxt = u8nv_pkg::REASON_BAD_CP;
        end
      end
    end

    // zero limit counts as one
    limit = (limit_r == '0) ? {{(u8nv_pkg::LimitW-1){1'b0}}, 1'b1} : limit_r;
    reason_nxt = err_nxt;
    if (reason_nxt == u8nv_pkg::REASON_OK && pend_nxt != 2'd0) begin
      reason_nxt = u8nv_pkg::REASON_TRUNCATED;
    end
    if (reason_nxt == u8nv_pkg::REASON_OK && cnt_nxt > {1'b0, limit}) begin
      reason_nxt = u8nv_pkg::REASON_TOO_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      seq_r  <= '0;
      acc_r  <= '0;
      cnt_r  <= '0;
      err_r  <= u8nv_pkg::REASON_OK;
    end else if (fire) begin
      if (in_last_r) begin
        pend_r <= '0;
        seq_r  <= '0;
        acc_r  <= '0;
        cnt_r  <= '0;
        err_r  <= u8nv_pkg::REASON_OK;
      end else begin
        pend_r <= pend_nxt;
        seq_r  <= seq_nxt;
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last_r) begin
      reason_r <= reason_nxt;
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.name_valid  = (reason_r == u8nv_pkg::REASON_OK);
  assign out_if.fail_reason = reason_r;

`ifndef NO_ASSERTIONS
  // an open sequence never expects more continuations than it started with
  a_pend_le_seq: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= seq_r)
    else $error("pending continuations exceed sequence length");

  // a recorded error holds until the name ends
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != u8nv_pkg::REASON_OK && !(fire && in_last_r)) |=> err_r == $past(err_r))
    else $error("first error changed inside a name");

  // a last byte is never decoded while an untaken verdict is pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_last_r) |-> (!out_v_r || out_if.ready))
    else $error("verdict overwritten");

  // a held input byte stays put until decoded
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !fire) |=> (in_v_r && $stable(in_byte_r) && $stable(in_last_r)))
    else $error("input register changed while stalled");
`endif

endmodule

/* dv/utf8_name_validator_unit_test.sv */
// ----------------------------------------------------------------------------
// utf8_name_validator_unit_test
// Streams names byte by byte into the validator under random source and sink
// idling, predicts each verdict from a behavioral decoder with its own copy
// of the name state and length limit, and checks every verdict word in order.
// ----------------------------------------------------------------------------
module utf8_name_validator_unit_test;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RAND_BYTES    = 220;
  localparam int LIM_W         = u8nv_pkg::LimitW;
  localparam int CNT_W         = u8nv_pkg::CountW;
  localparam int ACC_W         = u8nv_pkg::AccumW;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } name_byte_t;

  typedef struct packed {
    logic              name_valid;
    u8nv_pkg::reason_t fail_reason;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [LIM_W-1:0]    cfg_wr_data;

  u8nv_in_if  in_ch ();
  u8nv_out_if out_ch ();

  utf8_name_validator_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // stimulus and scoreboard
  name_byte_t  byte_q[$];
  logic [7:0]  name_buf[$];
  verdict_t    verdict_q[$];
  int          bytes_queued = 0;
  int          bytes_taken  = 0;
  int          mismatches   = 0;
  int          cycle_count  = 0;
  int          src_gap      = 0;
  int          sink_gap     = 0;
  bit          idle_on      = 1'b1;
  name_byte_t  next_word;
  verdict_t    seen_verdict;

  // decoder state mirrored from the block
  logic [LIM_W-1:0]  lim_bytes    = u8nv_pkg::LIMIT_RESET;
  logic [1:0]        cont_left    = '0;
  logic [1:0]        cont_total   = '0;
  logic [ACC_W-1:0]  cp_sum       = '0;
  logic [CNT_W-1:0]  seen_bytes   = '0;
  u8nv_pkg::reason_t early_reason = u8nv_pkg::REASON_OK;

  task automatic judge_byte(input logic [7:0] b, input logic last);
    logic [ACC_W-1:0]  floor_cp;
    logic [CNT_W-1:0]  lim;
    u8nv_pkg::reason_t why;
    verdict_t          v;
    if (seen_bytes != u8nv_pkg::COUNT_MAX) seen_bytes++;
    if (early_reason == u8nv_pkg::REASON_OK) begin
      if (cont_left == 2'd0) begin
        if (!b[7]) begin
          if (b < u8nv_pkg::ASCII_SPACE || b == u8nv_pkg::ASCII_DEL)
            early_reason = u8nv_pkg::REASON_CONTROL;
        end else if (b >= u8nv_pkg::LEAD2_LO && b <= u8nv_pkg::LEAD2_HI) begin
          cont_left  = 2'd1;
          cont_total = 2'd1;
          cp_sum     = ACC_W'(b[4:0]);
        end else if (b >= u8nv_pkg::LEAD3_LO && b <= u8nv_pkg::LEAD3_HI) begin
          cont_left  = 2'd2;
          cont_total = 2'd2;
          cp_sum     = ACC_W'(b[3:0]);
        end else if (b >= u8nv_pkg::LEAD4_LO && b <= u8nv_pkg::LEAD4_HI) begin
          cont_left  = 2'd3;
          cont_total = 2'd3;
          cp_sum     = ACC_W'(b[2:0]);
        end else begin
          early_reason = u8nv_pkg::REASON_BAD_LEAD;
        end
      end else if (b[7:6] != 2'b10) begin
        early_reason = u8nv_pkg::REASON_BAD_CONT;
      end else begin
        cp_sum    = {cp_sum[ACC_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          floor_cp = (cont_total == 2'd1) ? u8nv_pkg::CP_MIN2 :
                     (cont_total == 2'd2) ? u8nv_pkg::CP_MIN3 : u8nv_pkg::CP_MIN4;
          if (cp_sum < floor_cp || cp_sum > u8nv_pkg::CP_MAX ||
              (cp_sum >= u8nv_pkg::SURR_LO && cp_sum <= u8nv_pkg::SURR_HI) ||
              (cp_sum >= u8nv_pkg::C1_LO && cp_sum <= u8nv_pkg::C1_HI))
            early_reason = u8nv_pkg::REASON_BAD_CP;
        end
      end
    end
    if (last) begin
      lim = (lim_bytes == '0) ? CNT_W'(1) : CNT_W'(lim_bytes);
      why = early_reason;
      if (why == u8nv_pkg::REASON_OK && cont_left != 2'd0) why = u8nv_pkg::REASON_TRUNCATED;
      if (why == u8nv_pkg::REASON_OK && seen_bytes > lim) why = u8nv_pkg::REASON_TOO_LONG;
      v.name_valid  = (why == u8nv_pkg::REASON_OK);
      v.fail_reason = why;
      verdict_q.insert(verdict_q.size(), v);
      cont_left    = '0;
      cont_total   = '0;
      cp_sum       = '0;
      seen_bytes   = '0;
      early_reason = u8nv_pkg::REASON_OK;
    end
  endtask

  // source side: one word per handshake, random gaps between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.last_byte <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        judge_byte(in_ch.data_byte, in_ch.last_byte);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          next_word = byte_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= next_word.data;
          in_ch.last_byte <= next_word.last;
          if (idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 19);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // sink side: verdict check and random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          $error("verdict word with none expected: name_valid %0b, fail_reason %0d",
                 out_ch.name_valid, out_ch.fail_reason);
        end else begin
          seen_verdict = verdict_q.pop_front();
          if (out_ch.name_valid !== seen_verdict.name_valid) begin
            mismatches++;
            $error("name_valid: expected %0b, actual %0b",
                   seen_verdict.name_valid, out_ch.name_valid);
          end
          if (out_ch.fail_reason !== seen_verdict.fail_reason) begin
            mismatches++;
            $error("fail_reason: expected %0d, actual %0d",
                   seen_verdict.fail_reason, out_ch.fail_reason);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 19);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** utf8_name_validator_unit: FAILED **");
    $finish;
  end

  task automatic put_byte(input logic [7:0] b);
    name_buf.insert(name_buf.size(), b);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hbf));
  endfunction

  // mostly random inside the range, sometimes one of its ends
  function automatic logic [ACC_W-1:0] pick_in(int unsigned lo, int unsigned hi);
    if ($urandom_range(0, 7) == 0) return ACC_W'($urandom_range(0, 1) ? hi : lo);
    return ACC_W'($urandom_range(lo, hi));
  endfunction

  task automatic append_utf8(input logic [ACC_W-1:0] cp);
    if (cp < 21'h80) begin
      put_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic add_good_char();
    logic [ACC_W-1:0] cp;
    case ($urandom_range(0, 3))
      0: cp = pick_in('h20, 'h7e);
      1: cp = pick_in('ha0, 'h7ff);
      2: begin
        do cp = pick_in('h800, 'hffff);
        while (cp >= u8nv_pkg::SURR_LO && cp <= u8nv_pkg::SURR_HI);
      end
      default: cp = pick_in('h10000, 'h10ffff);
    endcase
    append_utf8(cp);
  endtask

  task automatic add_bad_char();
    int n;
    case ($urandom_range(0, 7))
      0: put_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1f))
                                       : u8nv_pkg::ASCII_DEL);
      1: put_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hc1))
                                       : 8'($urandom_range(8'hf5, 8'hff)));
      2: begin
        // lead, maybe one good continuation, then a non-continuation byte
        put_byte(8'($urandom_range(u8nv_pkg::LEAD2_LO, u8nv_pkg::LEAD4_HI)));
        if (name_buf[$] >= u8nv_pkg::LEAD3_LO && $urandom_range(0, 1)) put_byte(cont_byte());
        put_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7f))
                                      : 8'($urandom_range(8'hc0, 8'hff)));
      end
      3: begin
        // overlong forms
        case ($urandom_range(0, 2))
          0: begin
            put_byte(8'($urandom_range(8'hc0, 8'hc1)));
            put_byte(cont_byte());
          end
          1: begin
            put_byte(u8nv_pkg::LEAD3_LO);
            put_byte(8'($urandom_range(8'h80, 8'h9f)));
            put_byte(cont_byte());
          end
          default: begin
            put_byte(u8nv_pkg::LEAD4_LO);
            put_byte(8'($urandom_range(8'h80, 8'h8f)));
            put_byte(cont_byte());
            put_byte(cont_byte());
          end
        endcase
      end
      4: begin
        // surrogate
        put_byte(8'hed);
        put_byte(8'($urandom_range(8'ha0, 8'hbf)));
        put_byte(cont_byte());
      end
      5: begin
        // above the last code point
        put_byte(u8nv_pkg::LEAD4_HI);
        put_byte(8'($urandom_range(8'h90, 8'hbf)));
        put_byte(cont_byte());
        put_byte(cont_byte());
      end
      6: begin
        // c1 control encoded in two bytes
        put_byte(u8nv_pkg::LEAD2_LO);
        put_byte(8'($urandom_range(8'h80, 8'h9f)));
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // open sequence left at the end of the name
  task automatic add_cut_char();
    logic [7:0] lead;
    int         n;
    lead = 8'($urandom_range(u8nv_pkg::LEAD2_LO, u8nv_pkg::LEAD4_HI));
    put_byte(lead);
    n = (lead >= u8nv_pkg::LEAD4_LO) ? $urandom_range(0, 2) :
        (lead >= u8nv_pkg::LEAD3_LO) ? $urandom_range(0, 1) : 0;
    repeat (n) put_byte(cont_byte());
  endtask

  task automatic flush_name();
    name_byte_t w;
    foreach (name_buf[i]) begin
      w.data = name_buf[i];
      w.last = (i == name_buf.size() - 1);
      byte_q.insert(byte_q.size(), w);
    end
    bytes_queued += name_buf.size();
    name_buf.delete();
  endtask

  task automatic push_name(input logic [7:0] bytes_in[$]);
    name_buf = bytes_in;
    flush_name();
  endtask

  task automatic random_names(input int goal);
    int added;
    int n_chars;
    int bad_at;
    added = 0;
    while (added < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        n_chars = $urandom_range(1, 6);
        repeat (n_chars) put_byte(8'($urandom_range(0, 255)));
      end else begin
        n_chars = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        bad_at  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_chars - 1) : -1;
        for (int i = 0; i < n_chars; i++) begin
          if (i == bad_at) add_bad_char();
          else add_good_char();
        end
        if ($urandom_range(0, 9) == 0) add_cut_char();
      end
      added += name_buf.size();
      flush_name();
    end
  endtask

  task automatic ascii_name(input int n);
    repeat (n) put_byte(8'($urandom_range(u8nv_pkg::ASCII_SPACE, 8'h7e)));
    flush_name();
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_queued || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIM_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    lim_bytes    = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [LIM_W-1:0] lim_list[$];
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed names under the reset limit
    push_name('{8'h00});                       // control
    push_name('{8'h7f});                       // delete
    push_name('{8'h20});                       // lowest printable
    push_name('{8'hc2, 8'h80});                // c1 control
    push_name('{8'hc0});                       // overlong lead
    push_name('{8'hff});                       // never a lead
    push_name('{8'he0, 8'h9f, 8'hbf});         // overlong three-byte form
    push_name('{8'hed, 8'ha0, 8'h80});         // surrogate
    push_name('{8'hf4, 8'h90, 8'h80, 8'h80});  // past the last code point
    push_name('{8'hf4, 8'h8f, 8'hbf, 8'hbf});  // last code point
    push_name('{8'he0, 8'ha0, 8'h7e});         // open sequence cut by a bad byte
    push_name('{8'hc3});                       // truncated
    push_name('{8'h1f, 8'hc2});                // first error wins over truncation
    wait_drained();

    lim_list = '{16'd1, 16'd0, 16'd3, 16'd8, 16'd40};
    foreach (lim_list[i]) begin
      set_limit(lim_list[i]);
      random_names(RAND_BYTES);
      wait_drained();
    end

    // quiet tail: top limit, then names around the reset value
    idle_on = 1'b0;
    set_limit(16'hffff);
    random_names(150);
    wait_drained();
    set_limit(u8nv_pkg::LIMIT_RESET);
    ascii_name(255);
    ascii_name(256);
    random_names(100);
    wait_drained();

    if (mismatches == 0) begin
      $display("** utf8_name_validator_unit: PASSED **");
    end else begin
      $display("** utf8_name_validator_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/u8nv_pkg.sv
hdl/u8nv_in_if.sv
hdl/u8nv_out_if.sv
hdl/utf8_name_validator_unit.sv
dv/utf8_name_validator_unit_test.sv
